@@ src/heading_bank_aileron_cascade_assert.svh @@
// assertion macros for the heading, bank and aileron controller
`ifndef HEADING_BANK_AILERON_CASCADE_ASSERT_SVH
`define HEADING_BANK_AILERON_CASCADE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define HBAC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the trigger
`define HBAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/hbac_pkg.sv @@
// shared constants and the arccosine table builder for the heading/bank controller
`default_nettype none

package hbac_pkg;

  localparam int ACOS_TABLE_DEPTH = 1024;
  localparam int ACOS_W           = 14;

  localparam int QUARTER_TURN = 11520;
  localparam int HALF_TURN    = 23040;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // (2n-1)*(2n) for the twelve taylor terms
  localparam longint unsigned TAYLOR_DIV [12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIR_GAIN      = 3'd0,
    REG_ROLL_P_GAIN   = 3'd1,
    REG_ROLL_D_GAIN   = 3'd2,
    REG_BANK_LIMIT    = 3'd3,
    REG_AILERON_LIMIT = 3'd4,
    REG_MANUAL_THRESH = 3'd5
  } cfg_reg_e;

  // cosine in Q30 of h/128 degree, h in 0..23040, taylor series
  function automatic longint cos_q30(int unsigned h);
    logic neg;
    int unsigned hh;
    longint unsigned th;
    longint unsigned th2;
    longint unsigned term;
    longint sum;
    neg = 1'b0;
    hh = h;
    if (hh > QUARTER_TURN) begin
      hh = HALF_TURN - hh;
      neg = 1'b1;
    end
    th = (longint'(hh) * PI_Q30 + 64'(QUARTER_TURN)) / 64'(HALF_TURN);
    th2 = (th * th) >> 30;
    term = 64'd1 << 30;
    sum = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * th2) >> 30) / TAYLOR_DIV[n - 1];
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return neg ? -sum : sum;
  endfunction

  // acos of (-1 + 2i/depth) in 1/64 degree, rounded to nearest
  function automatic logic [ACOS_W-1:0] acos_entry(int depth, int i);
    longint rhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    rhs = longint'(2 * i - depth) * (64'sd1 <<< 30);
    lo = 0;
    hi = QUARTER_TURN;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (cos_q30(2 * mid + 1) * longint'(depth) > rhs) lo = mid + 1;
      else hi = mid;
    end
    return ACOS_W'(lo);
  endfunction

endpackage

`default_nettype wire

@@ src/heading_bank_aileron_cascade.sv @@
// heading to bank to aileron cascade controller, eleven stage pipeline
//
//  channel  | dir | payload                                   | handshake
//  s_axis   | in  | attitude terms, bearing, speed, rate, pwm | tvalid/tready
//  m_axis   | out | aileron_cmd, bank_cmd; tuser = manual     | tvalid/tready
//  cfg      | in  | register index and data                   | valid/ready
//
// one transaction per cycle sustained while m_axis_tready is high, set by the
// arccosine rom (one registered read port per lookup) and the multiplier chain.
// each stage holds only when it is full and the stage after it is held, so
// bubbles close up and no transaction is dropped or repeated under backpressure.
// reset clears the valid bits and loads the register defaults.
`default_nettype none

module heading_bank_aileron_cascade #(
  parameter int AcosTableDepth = hbac_pkg::ACOS_TABLE_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // heading_cos, heading_sin, roll_cos, bearing_deg, ground_speed, roll_rate,
  // mode_pulse, stick_pulse, zero fill
  input  wire logic [111:0]                     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // aileron_cmd, bank_cmd, zero fill
  output logic [31:0]                           m_axis_tdata,
  // manual
  output logic                                  m_axis_tuser,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [hbac_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [hbac_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int NS     = 11;
  localparam int IdxW   = $clog2(AcosTableDepth + 1);
  localparam int ProdW  = 16 + IdxW;
  localparam int AW     = hbac_pkg::ACOS_W;
  localparam logic signed [15:0] QOne     = 16'sd16384;
  localparam logic [11:0]        PulseMin = 12'd800;
  localparam logic [11:0]        PulseMax = 12'd2200;
  localparam logic [24:0]        RecipM   = 25'd17179870;  // ceil(2^33 / 500)
  localparam logic signed [21:0] RadQ32   = 22'sd1171271;
  localparam logic [12:0]        BankMax  = 13'd5760;
  localparam logic [14:0]        AilMax   = 15'd16384;

  // ---------------- configuration ----------------
  logic [15:0] dir_gain_q, roll_p_gain_q, roll_d_gain_q;
  logic [12:0] bank_limit_q;
  logic [14:0] aileron_limit_q;
  logic [11:0] manual_thresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_gain_q      <= 16'd1966;
      roll_p_gain_q   <= 16'd8192;
      roll_d_gain_q   <= 16'd410;
      bank_limit_q    <= 13'd1920;
      aileron_limit_q <= 15'd1638;
      manual_thresh_q <= 12'd1200;
    end else if (cfg_valid_i) begin
      case (hbac_pkg::cfg_reg_e'(cfg_index_i))
        hbac_pkg::REG_DIR_GAIN:      dir_gain_q      <= cfg_data_i;
        hbac_pkg::REG_ROLL_P_GAIN:   roll_p_gain_q   <= cfg_data_i;
        hbac_pkg::REG_ROLL_D_GAIN:   roll_d_gain_q   <= cfg_data_i;
        hbac_pkg::REG_BANK_LIMIT:    bank_limit_q    <= cfg_data_i[12:0];
        hbac_pkg::REG_AILERON_LIMIT: aileron_limit_q <= cfg_data_i[14:0];
        hbac_pkg::REG_MANUAL_THRESH: manual_thresh_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  logic [12:0] blim;
  logic [14:0] alim;
  assign blim = (bank_limit_q > BankMax) ? BankMax : bank_limit_q;
  assign alim = (aileron_limit_q > AilMax) ? AilMax : aileron_limit_q;

  // ---------------- arccosine rom ----------------
  logic [AW-1:0] acos_rom [AcosTableDepth+1];
  for (genvar g = 0; g <= AcosTableDepth; g++) begin : g_rom
    assign acos_rom[g] = hbac_pkg::acos_entry(AcosTableDepth, g);
  end

  // ---------------- flow control ----------------
  logic [NS:1] v_q;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !v_q[NS] || m_axis_tready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------- stage 1: unpack, clamp, table index ----------------
  logic signed [15:0] in_hc, in_hs, in_rc, in_rate;
  logic [8:0]         in_brg;
  logic [9:0]         in_spd;
  logic [11:0]        in_mode, in_stick;
  logic signed [15:0] hc_cl, rc_cl;
  logic [15:0]        hu, ru;
  logic [ProdW-1:0]   hprod, rprod;
  logic [11:0]        mode_cl, stick_cl;
  logic signed [12:0] sdiff;

  assign in_hc    = s_axis_tdata[15:0];
  assign in_hs    = s_axis_tdata[31:16];
  assign in_rc    = s_axis_tdata[47:32];
  assign in_brg   = s_axis_tdata[56:48];
  assign in_spd   = s_axis_tdata[66:57];
  assign in_rate  = s_axis_tdata[82:67];
  assign in_mode  = s_axis_tdata[94:83];
  assign in_stick = s_axis_tdata[106:95];

  always_comb begin
    hc_cl = in_hc;
    if (in_hc < -QOne) hc_cl = -QOne;
    if (in_hc > QOne)  hc_cl = QOne;
    rc_cl = in_rc;
    if (in_rc < -QOne) rc_cl = -QOne;
    if (in_rc > QOne)  rc_cl = QOne;
    hu = 16'(hc_cl + QOne);
    ru = 16'(rc_cl + QOne);
    hprod = ProdW'(hu) * ProdW'(AcosTableDepth) + ProdW'(16384);
    rprod = ProdW'(ru) * ProdW'(AcosTableDepth) + ProdW'(16384);
    mode_cl = in_mode;
    if (in_mode < PulseMin) mode_cl = PulseMin;
    if (in_mode > PulseMax) mode_cl = PulseMax;
    stick_cl = in_stick;
    if (in_stick < PulseMin) stick_cl = PulseMin;
    if (in_stick > PulseMax) stick_cl = PulseMax;
    sdiff = $signed({1'b0, stick_cl}) - 13'sd1500;
  end

  logic [IdxW-1:0]    s1_hidx_q, s1_ridx_q;
  logic               s1_hpos_q, s1_man_q, s1_sneg_q;
  logic [14:0]        s1_brg64_q;
  logic [9:0]         s1_spd_q, s1_sabs_q;
  logic signed [15:0] s1_rate_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_hidx_q  <= hprod[15 +: IdxW];
      s1_ridx_q  <= rprod[15 +: IdxW];
      s1_hpos_q  <= in_hs > 16'sd0;
      s1_brg64_q <= {in_brg, 6'd0};
      s1_spd_q   <= in_spd;
      s1_rate_q  <= in_rate;
      s1_man_q   <= mode_cl < manual_thresh_q;
      s1_sneg_q  <= sdiff[12];
      s1_sabs_q  <= sdiff[12] ? 10'(-sdiff) : 10'(sdiff);
    end
  end

  // ---------------- stage 2: rom read ----------------
  logic [AW-1:0]      s2_hraw_q, s2_racos_q;
  logic               s2_hpos_q, s2_man_q, s2_sneg_q;
  logic [14:0]        s2_brg64_q;
  logic [9:0]         s2_spd_q;
  logic signed [15:0] s2_rate_q;
  logic [23:0]        s2_n_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_hraw_q  <= acos_rom[s1_hidx_q];
      s2_racos_q <= acos_rom[s1_ridx_q];
      s2_hpos_q  <= s1_hpos_q;
      s2_brg64_q <= s1_brg64_q;
      s2_spd_q   <= s1_spd_q;
      s2_rate_q  <= s1_rate_q;
      s2_man_q   <= s1_man_q;
      s2_sneg_q  <= s1_sneg_q;
      s2_n_q     <= {s1_sabs_q, 14'd0} + 24'd250;
    end
  end

  // ---------------- stage 3: heading mirror and error wrap ----------------
  logic [14:0]        head3;
  logic signed [16:0] err3_raw, err3;

  always_comb begin
    head3 = s2_hpos_q ? 15'(15'(hbac_pkg::HALF_TURN) - 15'(s2_hraw_q)) : 15'(s2_hraw_q);
    err3_raw = $signed({2'b00, head3}) - $signed({2'b00, s2_brg64_q});
    err3 = err3_raw;
    if (err3_raw < -17'sd11520)     err3 = err3_raw + 17'sd23040;
    else if (err3_raw > 17'sd11520) err3 = err3_raw - 17'sd23040;
  end

  logic signed [14:0] s3_err_q;
  logic [9:0]         s3_spd_q;
  logic [AW-1:0]      s3_racos_q;
  logic signed [15:0] s3_rate_q;
  logic               s3_man_q, s3_sneg_q;
  logic [48:0]        s3_p_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_err_q   <= 15'(err3);
      s3_spd_q   <= s2_spd_q;
      s3_racos_q <= s2_racos_q;
      s3_rate_q  <= s2_rate_q;
      s3_man_q   <= s2_man_q;
      s3_sneg_q  <= s2_sneg_q;
      s3_p_q     <= 49'(s2_n_q) * 49'(RecipM);
    end
  end

  // ---------------- stage 4: error times speed, manual value ----------------
  logic [15:0] q4;
  assign q4 = s3_p_q[48:33];

  logic signed [24:0] s4_es_q;
  logic [AW-1:0]      s4_racos_q;
  logic signed [15:0] s4_rate_q, s4_aman_q;
  logic               s4_man_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_es_q    <= 25'(s3_err_q) * $signed({15'd0, s3_spd_q});
      s4_racos_q <= s3_racos_q;
      s4_rate_q  <= s3_rate_q;
      s4_man_q   <= s3_man_q;
      s4_aman_q  <= s3_sneg_q ? -$signed(q4) : $signed(q4);
    end
  end

  // ---------------- stage 5: times direction gain ----------------
  logic signed [40:0] s5_bp_q;
  logic [AW-1:0]      s5_racos_q;
  logic signed [15:0] s5_rate_q, s5_aman_q;
  logic               s5_man_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_bp_q    <= 41'(s4_es_q) * $signed({25'd0, dir_gain_q});
      s5_racos_q <= s4_racos_q;
      s5_rate_q  <= s4_rate_q;
      s5_man_q   <= s4_man_q;
      s5_aman_q  <= s4_aman_q;
    end
  end

  // ---------------- stage 6: round and limit bank ----------------
  logic [40:0] bmag6;
  logic [24:0] brnd6;
  logic [12:0] blim6;
  logic signed [13:0] bank6;

  always_comb begin
    bmag6 = s5_bp_q[40] ? 41'(-s5_bp_q) : 41'(s5_bp_q);
    brnd6 = 25'((bmag6 + 41'd32768) >> 16);
    blim6 = (brnd6 > 25'(blim)) ? blim : brnd6[12:0];
    bank6 = s5_bp_q[40] ? -$signed({1'b0, blim6}) : $signed({1'b0, blim6});
  end

  logic signed [13:0] s6_bank_q;
  logic [AW-1:0]      s6_racos_q;
  logic signed [15:0] s6_rate_q, s6_aman_q;
  logic               s6_man_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_bank_q  <= bank6;
      s6_racos_q <= s5_racos_q;
      s6_rate_q  <= s5_rate_q;
      s6_man_q   <= s5_man_q;
      s6_aman_q  <= s5_aman_q;
    end
  end

  // ---------------- stage 7: bank error, rate term ----------------
  logic signed [15:0] s7_e_q, s7_aman_q;
  logic signed [31:0] s7_rd_q;
  logic signed [13:0] s7_bank_q;
  logic               s7_man_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      // quarter turn of 90 degrees is 5760 in 1/64 degree
      s7_e_q    <= 16'(s6_bank_q) + 16'sd5760 - $signed({2'b00, s6_racos_q});
      s7_rd_q   <= 32'(s6_rate_q) * 32'($signed(roll_d_gain_q));
      s7_bank_q <= s6_bank_q;
      s7_man_q  <= s6_man_q;
      s7_aman_q <= s6_aman_q;
    end
  end

  // ---------------- stage 8: times proportional gain ----------------
  logic signed [32:0] s8_ep_q;
  logic signed [31:0] s8_rd_q;
  logic signed [13:0] s8_bank_q;
  logic signed [15:0] s8_aman_q;
  logic               s8_man_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_ep_q   <= 33'(s7_e_q) * $signed({17'd0, roll_p_gain_q});
      s8_rd_q   <= s7_rd_q;
      s8_bank_q <= s7_bank_q;
      s8_man_q  <= s7_man_q;
      s8_aman_q <= s7_aman_q;
    end
  end

  // ---------------- stage 9: degree to radian ----------------
  logic signed [53:0] s9_a_q;
  logic signed [31:0] s9_rd_q;
  logic signed [13:0] s9_bank_q;
  logic signed [15:0] s9_aman_q;
  logic               s9_man_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_a_q    <= 54'(s8_ep_q) * 54'(RadQ32);
      s9_rd_q   <= s8_rd_q;
      s9_bank_q <= s8_bank_q;
      s9_man_q  <= s8_man_q;
      s9_aman_q <= s8_aman_q;
    end
  end

  // ---------------- stage 10: sum ----------------
  logic signed [53:0] s10_acc_q;
  logic signed [13:0] s10_bank_q;
  logic signed [15:0] s10_aman_q;
  logic               s10_man_q;

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s10_acc_q  <= s9_a_q + (54'(s9_rd_q) <<< 20);
      s10_bank_q <= s9_bank_q;
      s10_man_q  <= s9_man_q;
      s10_aman_q <= s9_aman_q;
    end
  end

  // ---------------- stage 11: round, limit, select ----------------
  logic [53:0]        amag11;
  logic [23:0]        arnd11;
  logic [14:0]        alim11;
  logic signed [15:0] aauto11;

  always_comb begin
    amag11  = s10_acc_q[53] ? 54'(-s10_acc_q) : 54'(s10_acc_q);
    arnd11  = 24'((amag11 + 54'd536870912) >> 30);
    alim11  = (arnd11 > 24'(alim)) ? alim : arnd11[14:0];
    aauto11 = s10_acc_q[53] ? -$signed({1'b0, alim11}) : $signed({1'b0, alim11});
  end

  logic signed [15:0] s11_ail_q;
  logic signed [13:0] s11_bank_q;
  logic               s11_man_q;

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      s11_ail_q  <= s10_man_q ? s10_aman_q : aauto11;
      s11_bank_q <= s10_bank_q;
      s11_man_q  <= s10_man_q;
    end
  end

  assign m_axis_tvalid = v_q[NS];
  assign m_axis_tdata  = {2'b00, s11_bank_q, s11_ail_q};
  assign m_axis_tuser  = s11_man_q;

endmodule

`default_nettype wire

@@ src/hbac_checker.sv @@
// port level checks for the heading/bank controller, bound to the top level
`default_nettype none

`include "heading_bank_aileron_cascade_assert.svh"

module hbac_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  logic signed [15:0] ail;
  logic signed [13:0] bank;
  assign ail  = m_axis_tdata[15:0];
  assign bank = m_axis_tdata[29:16];

  `HBAC_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled transaction changed")
  `HBAC_ASSERT_SAME(a_bank, clk_i, rst_ni, m_axis_tvalid, bank >= -14'sd5760 && bank <= 14'sd5760, "bank command out of range")
  `HBAC_ASSERT_SAME(a_auto, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, ail >= -16'sd16384 && ail <= 16'sd16384, "automatic aileron over limit")
  `HBAC_ASSERT_SAME(a_man, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, ail >= -16'sd22938 && ail <= 16'sd22938, "manual aileron out of range")

endmodule

bind heading_bank_aileron_cascade hbac_checker u_hbac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ test/heading_bank_aileron_cascade_tb.sv @@
// testbench for the heading, bank and aileron cascade controller
`default_nettype none

module heading_bank_aileron_cascade_tb;

  localparam int DEPTH = hbac_pkg::ACOS_TABLE_DEPTH;
  localparam int PIPE_LAT = 11;
  localparam longint RAD_Q32 = 1171271;

  typedef struct packed {
    logic signed [15:0] hcos;
    logic signed [15:0] hsin;
    logic signed [15:0] rcos;
    logic [8:0]         bearing;
    logic [9:0]         speed;
    logic signed [15:0] rate;
    logic [11:0]        mode;
    logic [11:0]        stick;
  } att_t;

  typedef struct packed {
    logic signed [15:0] ail;
    logic signed [13:0] bank;
    logic               man;
  } cmd_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [111:0] s_axis_tdata;
  logic [31:0] m_axis_tdata;
  logic cfg_valid_i, cfg_ready_o;
  logic [hbac_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [hbac_pkg::CFG_DATA_W-1:0] cfg_data_i;

  heading_bank_aileron_cascade i_dut (.*);

  // local gains and limits mirrored from the register writes
  logic [15:0] dir_gain, p_gain;
  logic signed [15:0] d_gain;
  logic [12:0] blim_reg;
  logic [14:0] alim_reg;
  logic [11:0] thresh;
  int acos_rom[DEPTH+1];

  cmd_t cmd_fifo[$];
  int errors, n_sent, n_got;
  logic hold_rx;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // own cosine series for the arccosine rom
  function automatic longint cosine_q30(int unsigned h);
    longint unsigned th, th2, term;
    longint sum;
    logic neg;
    neg = 1'b0;
    if (h > hbac_pkg::QUARTER_TURN) begin
      h = hbac_pkg::HALF_TURN - h;
      neg = 1'b1;
    end
    th = (longint'(h) * hbac_pkg::PI_Q30 + hbac_pkg::QUARTER_TURN) / hbac_pkg::HALF_TURN;
    th2 = (th * th) >> 30;
    term = 64'd1 << 30;
    sum = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * th2) >> 30) / longint'((2 * n - 1) * (2 * n));
      sum = (n % 2) ? sum - longint'(term) : sum + longint'(term);
    end
    return neg ? -sum : sum;
  endfunction

  task automatic fill_rom();
    longint rhs;
    int unsigned lo, hi, mid;
    for (int i = 0; i <= DEPTH; i++) begin
      rhs = longint'(2 * i - DEPTH) * (64'sd1 <<< 30);
      lo = 0;
      hi = hbac_pkg::QUARTER_TURN;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (cosine_q30(2 * mid + 1) * longint'(DEPTH) > rhs) lo = mid + 1;
        else hi = mid;
      end
      acos_rom[i] = lo;
    end
  endtask

  function automatic int acos_of(int c);
    int idx;
    if (c < -16384) c = -16384;
    if (c > 16384) c = 16384;
    idx = ((c + 16384) * DEPTH + 16384) >>> 15;
    if (idx > DEPTH) idx = DEPTH;
    return acos_rom[idx];
  endfunction

  function automatic longint round_away(longint v, int s);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic int pwm_clamp(int p);
    return p < 800 ? 800 : (p > 2200 ? 2200 : p);
  endfunction

  function automatic cmd_t steer_cmd(att_t a);
    cmd_t r;
    int hdg, err, blim, alim, e, mode, d, q;
    longint bank, acc;
    hdg = acos_of(a.hcos);
    if (a.hsin > 0) hdg = hbac_pkg::HALF_TURN - hdg;
    err = hdg - int'(a.bearing) * 64;
    if (err < -hbac_pkg::QUARTER_TURN) err += hbac_pkg::HALF_TURN;
    else if (err > hbac_pkg::QUARTER_TURN) err -= hbac_pkg::HALF_TURN;
    bank = round_away(longint'(err) * longint'(a.speed) * longint'(dir_gain), 16);
    blim = blim_reg > 5760 ? 5760 : int'(blim_reg);
    if (bank < -blim) bank = -blim;
    if (bank > blim) bank = blim;
    e = int'(bank) + hbac_pkg::QUARTER_TURN / 2 - acos_of(a.rcos);
    acc = longint'(e) * RAD_Q32 * longint'(p_gain)
        + longint'(a.rate) * longint'(d_gain) * (64'sd1 <<< 20);
    acc = round_away(acc, 30);
    alim = alim_reg > 16384 ? 16384 : int'(alim_reg);
    if (acc < -alim) acc = -alim;
    if (acc > alim) acc = alim;
    mode = pwm_clamp(a.mode);
    r.man = mode < int'(thresh);
    r.ail = 16'(acc);
    if (r.man) begin
      d = pwm_clamp(a.stick) - 1500;
      q = ((d < 0 ? -d : d) * 16384 + 250) / 500;
      r.ail = 16'(d < 0 ? -q : q);
    end
    r.bank = 14'(bank);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_got);
  endtask

  // output side: random stalls, mostly short with an occasional long one
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_rx) m_axis_tready <= 1'b0;
      else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 63) == 0) begin
        stall = $urandom_range(10, 40);
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= ($urandom_range(0, 4) != 0);
    end
  end

  always @(posedge clk_i) begin
    cmd_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_got++;
      if (cmd_fifo.size() == 0) begin
        report_mismatch("unexpected result transaction", n_got, 0);
      end else begin
        w = cmd_fifo.pop_front();
        if ($signed(m_axis_tdata[15:0]) != w.ail)
          report_mismatch("aileron_cmd", $signed(m_axis_tdata[15:0]), w.ail);
        if ($signed(m_axis_tdata[29:16]) != w.bank)
          report_mismatch("bank_cmd", $signed(m_axis_tdata[29:16]), w.bank);
        if (m_axis_tuser != w.man) report_mismatch("manual", m_axis_tuser, w.man);
      end
    end
  end

  // valid stays high after the last transaction until the caller idles the input
  task automatic send_item(att_t a, bit gaps = 1);
    if (gaps && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 2))
        @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, a.stick, a.mode, a.rate, a.speed, a.bearing, a.rcos, a.hsin,
                     a.hcos};
    do @(posedge clk_i); while (!s_axis_tready);
    cmd_fifo.push_back(steer_cmd(a));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(hbac_pkg::cfg_reg_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hbac_pkg::REG_DIR_GAIN: dir_gain = val;
      hbac_pkg::REG_ROLL_P_GAIN: p_gain = val;
      hbac_pkg::REG_ROLL_D_GAIN: d_gain = val;
      hbac_pkg::REG_BANK_LIMIT: blim_reg = val[12:0];
      hbac_pkg::REG_AILERON_LIMIT: alim_reg = val[14:0];
      default: thresh = val[11:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cmd_fifo.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 4) @(negedge clk_i);
  endtask

  function automatic att_t rand_att();
    att_t a;
    a.hcos = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
    a.hsin = 16'($urandom);
    a.rcos = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
    a.bearing = $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(0, 359));
    a.speed = 10'($urandom);
    a.rate = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
    a.mode = $urandom_range(0, 9) == 0 ? 12'($urandom) : 12'($urandom_range(800, 2200));
    a.stick = $urandom_range(0, 9) == 0 ? 12'($urandom) : 12'($urandom_range(800, 2200));
    return a;
  endfunction

  task automatic test_directed();
    att_t a;
    int hc[5] = '{-16384, 16384, 0, -32768, 32767};
    for (int i = 0; i < 5; i++) begin
      a = '{hcos: 16'(hc[i]), hsin: (i % 2) ? 16'sd100 : -16'sd5, rcos: 16'(hc[4 - i]),
            bearing: (i == 3) ? 9'd511 : 9'(i * 90), speed: (i == 2) ? 10'd0 : 10'd1023,
            rate: (i % 2) ? -16'sd32768 : 16'sd32767, mode: 12'd2200, stick: 12'd1500};
      send_item(a);
    end
    // manual passthrough with stick extremes and out of range pulses, then mode at and above the threshold
    a = '{16'sd0, 16'sd0, 16'sd0, 9'd0, 10'd0, 16'sd0, 12'd800, 12'd800};
    send_item(a);
    a.stick = 12'd2200; send_item(a);
    a.stick = 12'd4095; a.mode = 12'd0; send_item(a);
    a.stick = 12'd0; a.mode = 12'd1199; send_item(a);
    a.stick = 12'd1501; a.mode = 12'd1200; send_item(a);
    a.mode = 12'd4095; send_item(a);
    // heading wrap around bearing 0 and 359
    a = '{16'sd16384, 16'sd1, 16'sd0, 9'd359, 10'd500, 16'sd0, 12'd2000, 12'd1500};
    send_item(a);
    a.bearing = 9'd0; a.hcos = 16'sd16000; a.hsin = 16'sd3000; send_item(a);
    a.hsin = 16'sd0; send_item(a);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_item(rand_att());
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      repeat (80) @(posedge clk_i);
      for (int i = 0; i < 40; i++) send_item(rand_att(), 0);
    join_any
    hold_rx = 1'b0;
    wait fork;
  endtask

  task automatic test_registers();
    write_reg(hbac_pkg::REG_DIR_GAIN, 16'hFFFF);
    write_reg(hbac_pkg::REG_ROLL_P_GAIN, 16'hFFFF);
    write_reg(hbac_pkg::REG_ROLL_D_GAIN, 16'h8000);
    write_reg(hbac_pkg::REG_BANK_LIMIT, 16'h1FFF);
    write_reg(hbac_pkg::REG_AILERON_LIMIT, 16'h7FFF);
    write_reg(hbac_pkg::REG_MANUAL_THRESH, 16'd800);
    test_random(150);
    drain();
    write_reg(hbac_pkg::REG_DIR_GAIN, 16'd0);
    write_reg(hbac_pkg::REG_ROLL_P_GAIN, 16'd0);
    write_reg(hbac_pkg::REG_ROLL_D_GAIN, 16'h7FFF);
    write_reg(hbac_pkg::REG_BANK_LIMIT, 16'd0);
    write_reg(hbac_pkg::REG_AILERON_LIMIT, 16'd0);
    write_reg(hbac_pkg::REG_MANUAL_THRESH, 16'd4095);
    test_random(100);
    drain();
    for (int k = 0; k < 4; k++) begin
      write_reg(hbac_pkg::REG_DIR_GAIN, 16'($urandom));
      write_reg(hbac_pkg::REG_ROLL_P_GAIN, 16'($urandom));
      write_reg(hbac_pkg::REG_ROLL_D_GAIN, 16'($urandom));
      write_reg(hbac_pkg::REG_BANK_LIMIT, 16'($urandom_range(0, 5760)));
      write_reg(hbac_pkg::REG_AILERON_LIMIT, 16'($urandom_range(0, 16384)));
      write_reg(hbac_pkg::REG_MANUAL_THRESH, 16'($urandom_range(800, 2200)));
      test_random(120);
      drain();
    end
  endtask

  initial begin
    errors = 0; n_sent = 0; n_got = 0; hold_rx = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_valid_i = 1'b0; cfg_index_i = hbac_pkg::REG_DIR_GAIN; cfg_data_i = '0;
    dir_gain = 16'd1966; p_gain = 16'd8192; d_gain = 16'sd410;
    blim_reg = 13'd1920; alim_reg = 15'd1638; thresh = 12'd1200;
    fill_rom();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(250);
    test_backpressure();
    drain();
    test_registers();
    drain();
    $display("sent %0d attitude samples, checked %0d commands", n_sent, n_got);
    $display("covered default, extreme and random gains plus output stalls");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
